/* sv/a64_pkg.sv */
// Package of shared types and operation codes for the integer execute unit.
package a64_pkg;

    typedef enum logic [3:0] {
        OP_AND = 4'd0, OP_EOR = 4'd1, OP_SUB = 4'd2, OP_ORR = 4'd3,
        OP_ADD = 4'd4, OP_ADC = 4'd5, OP_SBC = 4'd6, OP_MOVM = 4'd7,
        OP_SBFM = 4'd8, OP_BFM = 4'd9, OP_CSEL = 4'd10, OP_CCMP = 4'd11,
        OP_REV = 4'd12, OP_CLZ = 4'd13, OP_EXT = 4'd14, OP_NONE = 4'd15
    } t_op;

    localparam logic [3:0] SH_LSL = 4'd0;
    localparam logic [3:0] SH_LSR = 4'd1;
    localparam logic [3:0] SH_ASR = 4'd2;
    localparam logic [3:0] SH_ROR = 4'd3;
    localparam logic [3:0] SH_UXTB = 4'd8;
    localparam logic [3:0] SH_UXTH = 4'd9;
    localparam logic [3:0] SH_UXTW = 4'd10;
    localparam logic [3:0] SH_UXTX = 4'd11;
    localparam logic [3:0] SH_SXTB = 4'd12;
    localparam logic [3:0] SH_SXTH = 4'd13;
    localparam logic [3:0] SH_SXTW = 4'd14;
    localparam logic [3:0] SH_SXTX = 4'd15;

    localparam logic [63:0] MASK32 = 64'h0000_0000_ffff_ffff;

    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  shift_op;
        logic        is64;
        logic        invert_operand;
        logic        invert_result;
        logic [63:0] src_a;
        logic [63:0] src_b;
        logic [15:0] src_c;
        logic [63:0] wmask;
        logic [63:0] tmask;
        logic [3:0]  flags_in;
    } t_in;

    typedef struct packed {
        logic [63:0] result;
        logic [3:0]  flags_out;
    } t_out;

    // Word after the shifter stage.
    typedef struct packed {
        t_in         w;
        logic [63:0] m;
        logic        ex;
    } t_s1;

    // Word after the execute stage.
    typedef struct packed {
        logic [63:0] d;
        logic [3:0]  fl;
        logic        nz;
        logic        is64;
    } t_s2;

    function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
        logic r;
        case (cc[3:1])
            3'd0: r = f[2];
            3'd1: r = f[1];
            3'd2: r = f[3];
            3'd3: r = f[0];
            3'd4: r = f[1] & ~f[2];
            3'd5: r = (f[3] == f[0]);
            3'd6: r = ~f[2] & (f[3] == f[0]);
            default: r = 1'b1;
        endcase
        if (cc[3:1] == 3'd7) return 1'b1;
        return cc[0] ? ~r : r;
    endfunction

endpackage

/* sv/a64_shift.sv */
// Shifter stage: shift or extend of operand B, then inversion; condition check.
module a64_shift import a64_pkg::*; (
    input  t_in         i_w,
    output logic [63:0] o_m,
    output logic        o_ex
);
    logic [63:0] b, lo, e, m;
    logic [5:0]  n, amt;
    logic [15:0] shc;
    logic [127:0] sx;

    always_comb begin
        b   = i_w.src_b;
        lo  = b & MASK32;
        shc = (i_w.mode == OP_SBFM || i_w.mode == OP_BFM) ? {8'd0, i_w.src_c[7:0]} : i_w.src_c;
        amt = shc[5:0];
        n   = i_w.is64 ? shc[5:0] : {1'b0, shc[4:0]};
        e   = b;
        sx  = '0;
        m   = b;
        case (i_w.shift_op)
            SH_LSL: m = i_w.is64 ? (b << n) : ((lo << n) & MASK32);
            SH_LSR: m = i_w.is64 ? (b >> n) : (lo >> n);
            SH_ASR: begin
                e = i_w.is64 ? b : {{32{b[31]}}, b[31:0]};
                m = $signed(e) >>> n;
            end
            SH_ROR: begin
                if (i_w.is64) begin
                    sx = {b, b} >> n;
                    m  = sx[63:0];
                end else begin
                    sx = {64'd0, b[31:0], b[31:0]} >> n;
                    m  = {32'd0, sx[31:0]};
                end
            end
            SH_UXTB: m = {56'd0, b[7:0]} << amt;
            SH_UXTH: m = {48'd0, b[15:0]} << amt;
            SH_UXTW: m = lo << amt;
            SH_UXTX, SH_SXTX: m = b << amt;
            SH_SXTB: m = {{56{b[7]}}, b[7:0]} << amt;
            SH_SXTH: m = {{48{b[15]}}, b[15:0]} << amt;
            SH_SXTW: m = {{32{b[31]}}, b[31:0]} << amt;
            default: m = b;
        endcase
        o_m  = i_w.invert_operand ? ~m : m;
        o_ex = cond_holds(i_w.wmask[3:0], i_w.flags_in);
    end
endmodule

/* sv/a64_exec.sv */
// Execute stage: adder, logic, bitfield, select, reverse, count and extract.
module a64_exec import a64_pkg::*; (
    input  t_s1 i_s,
    output t_s2 o_s
);
    t_in         w;
    logic [63:0] a, b, m, d, bm, am, bot, top, rb, sx64, cv;
    logic [63:0] acc_a, acc_b, sum;
    logic        cin, use_add, at, bt, dt;
    logic [3:0]  fl;
    logic [6:0]  cnt;
    logic [127:0] ex;
    logic [5:0]  k;
    logic [2:0]  gi;

    always_comb begin
        w = i_s.w;
        a = w.src_a;
        b = w.src_b;
        m = i_s.m;
        am = w.is64 ? '1 : MASK32;
        // Shared adder.
        acc_a = a & am;
        acc_b = m;
        cin = 1'b0;
        use_add = 1'b0;
        case (w.mode)
            OP_SUB: begin acc_b = ~m; cin = 1'b1; use_add = 1'b1; end
            OP_ADD: use_add = 1'b1;
            OP_ADC: begin cin = w.flags_in[1]; use_add = 1'b1; end
            OP_SBC: begin acc_b = ~m; cin = w.flags_in[1]; use_add = 1'b1; end
            OP_CCMP: begin cin = w.invert_operand; use_add = i_s.ex; end
            default: ;
        endcase
        acc_b = acc_b & am;
        sum = (acc_a + acc_b + {63'd0, cin}) & am;
        at = w.is64 ? acc_a[63] : acc_a[31];
        bt = w.is64 ? acc_b[63] : acc_b[31];
        dt = w.is64 ? sum[63] : sum[31];
        fl = {dt, sum == 64'd0, (at & bt) | (~dt & (at | bt)), (at == bt) && (dt != at)};

        for (int i = 0; i < 64; i++) rb[i] = a[63 - i];
        cv = w.src_b == 64'd1 ? ((a ^ (a << 1)) | 64'd1) : a;
        if (!w.is64) cv = {cv[31:0], 32'd0};
        cnt = 7'd64;
        for (int i = 0; i < 64; i++) if (cv[i]) cnt = 7'(63 - i);
        if (!w.is64 && cnt > 7'd32) cnt = 7'd32;

        d = '0;
        bot = '0;
        top = '0;
        bm = '0;
        k = '0;
        ex = '0;
        gi = '0;
        o_s.fl = 4'd0;
        case (w.mode)
            OP_AND: d = a & m;
            OP_EOR: d = a ^ m;
            OP_ORR: d = a | m;
            OP_SUB, OP_ADD, OP_ADC, OP_SBC: begin d = sum; o_s.fl = fl; end
            OP_MOVM: begin
                d = (a & ~w.wmask) | (m & w.wmask);
                if (w.invert_result) d = ~d;
            end
            OP_SBFM, OP_BFM: begin
                bot = (a & ~w.wmask) | (m & w.wmask);
                top = (w.mode == OP_SBFM) ? {64{b[w.src_c[13:8]]}} : a;
                d = (top & ~w.tmask) | (bot & w.tmask);
            end
            OP_CSEL: begin
                if (i_s.ex) d = a;
                else begin
                    bm = w.invert_result ? ~b : b;
                    d = (w.tmask != 64'd0) ? bm + 64'd1 : bm;
                end
            end
            OP_CCMP: o_s.fl = use_add ? fl : w.tmask[3:0];
            OP_REV: begin
                if (b == 64'd0) d = w.is64 ? rb : {32'd0, rb[63:32]};
                else begin
                    for (int i = 0; i < 8; i++) begin
                        gi = 3'(i);
                        if (b == 64'd1) gi = gi ^ 3'd1;
                        else if (b == 64'd2) gi = gi ^ 3'd3;
                        else gi = gi ^ 3'd7;
                        d[8*gi +: 8] = a[8*i +: 8];
                    end
                end
            end
            OP_CLZ: d = {57'd0, cnt};
            OP_EXT: begin
                if (w.is64) begin
                    k = w.wmask[5:0];
                    ex = {a, m} >> k;
                    d = ex[63:0];
                end else begin
                    k = {1'b0, w.wmask[4:0]};
                    ex = {64'd0, a[31:0], m[31:0]} >> k;
                    d = {32'd0, ex[31:0]};
                end
            end
            default: d = '0;
        endcase
        sx64 = d;
        o_s.d = w.is64 ? sx64 : (sx64 & MASK32);
        o_s.nz = (w.mode == OP_AND || w.mode == OP_EOR || w.mode == OP_ORR);
        o_s.is64 = w.is64;
    end
endmodule

/* sv/a64_integer_alu.sv */
// Top level of the three-stage integer execute pipeline.
// Usage:
//  Input channel i_valid/o_ready carries one t_in word per instruction;
//  output channel o_valid/i_ready carries one t_out word (result, NZCV).
//  Pipeline: stage 1 registers the input, stage 2 the shifted operand,
//  stage 3 the executed result with logic flags resolved in the last stage.
//  An accepted word passes the input, shift and execute registers to o_valid;
//  throughput is one word every cycle while i_ready does not stall the pipeline.
//  A stall on i_ready freezes every stage that holds a word ahead of a
//  bubble; empty stages keep filling, so nothing is lost or repeated.
//  o_ready is low only while the whole pipeline is full and stalled.
//  Synchronous active-low reset empties all stages; payloads are not reset.
module a64_integer_alu import a64_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    logic r_v0, r_v1, r_v2;
    t_in  r_d0;
    t_s1  r_d1, n_d1;
    t_s2  r_d2, n_d2;
    logic en0, en1, en2;
    logic [63:0] m;
    logic ex;

    assign en2 = ~r_v2 | i_ready;
    assign en1 = ~r_v1 | en2;
    assign en0 = ~r_v0 | en1;
    assign o_ready = en0;

    a64_shift u_shift (.i_w(r_d0), .o_m(m), .o_ex(ex));
    assign n_d1 = '{w: r_d0, m: m, ex: ex};
    a64_exec u_exec (.i_s(r_d1), .o_s(n_d2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
        end
        if (en0) r_d0 <= i_data;
        if (en1) r_d1 <= n_d1;
        if (en2) r_d2 <= n_d2;
    end

    always_comb begin
        o_valid = r_v2;
        o_data.result = r_d2.d;
        if (r_d2.nz)
            o_data.flags_out = {r_d2.is64 ? r_d2.d[63] : r_d2.d[31], r_d2.d == 64'd0, 2'b00};
        else
            o_data.flags_out = r_d2.fl;
    end
endmodule
